// ----- design/flm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package flm_pkg;
  localparam int LotDepthDefault = 16;
  localparam logic [1:0] KIND_EXIT = 2'd0;
  localparam logic [1:0] KIND_EPISODE = 2'd1;
  localparam logic [1:0] KIND_OVERFLOW = 2'd2;
  localparam logic [22:0] QTY_MAX = 23'h7FFFFF;

  typedef struct packed {
    logic load;
    logic head_rd;
    logic match;
    logic mul_done;
    logic emit_exit;
    logic emit_episode;
    logic emit_overflow;
    logic push;
    logic last;
  } flm_cmd_t;

  typedef struct packed {
    logic qty_zero;
    logic has_lots;
    logic opposing;
    logic remaining_zero;
    logic full;
    logic was_open;
  } flm_status_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) sat_add = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else sat_add = s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) sat_sub = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else sat_sub = s[63:0];
  endfunction
endpackage
`default_nettype wire

// ----- design/flm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module flm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire flm_pkg::flm_status_t st,
  output flm_pkg::flm_cmd_t       cmd
);
  import flm_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_READ  = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_EXIT  = 7'b0010000,
    S_EPI   = 7'b0100000,
    S_TAIL  = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.qty_zero) state_next = S_IDLE;
        else if (!st.remaining_zero && st.has_lots && st.opposing) begin
          cmd.head_rd = 1'b1;
          state_next = S_READ;
        end else if (st.was_open && !st.has_lots) state_next = S_EPI;
        else state_next = S_TAIL;
      end
      S_READ: begin
        cmd.match = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul_done = 1'b1;
        state_next = S_EXIT;
      end
      S_EXIT: begin
        cmd.emit_exit = 1'b1;
        cmd.last = st.remaining_zero && st.has_lots;
        state_next = S_CHECK;
        if (cmd.last) state_next = S_IDLE;
      end
      S_EPI: begin
        cmd.emit_episode = 1'b1;
        cmd.last = 1'b1;
        state_next = st.remaining_zero ? S_IDLE : S_TAIL;
      end
      S_TAIL: begin
        if (!st.remaining_zero) begin
          if (st.full) begin
            cmd.emit_overflow = 1'b1;
            cmd.last = 1'b1;
          end else cmd.push = 1'b1;
        end
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- design/flm_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module flm_datapath #(
  parameter int LOT_DEPTH = flm_pkg::LotDepthDefault
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire flm_pkg::flm_cmd_t    cmd,
  output flm_pkg::flm_status_t      st,
  input  wire logic [31:0]          fill_time,
  input  wire logic signed [23:0]   fill_qty,
  input  wire logic [31:0]          fill_price,
  output logic                      strobe,
  output logic [1:0]                kind,
  output logic [31:0]               event_time,
  output logic [31:0]               open_time,
  output logic signed [1:0]         direction,
  output logic [22:0]               matched_qty,
  output logic [31:0]               exit_price,
  output logic [31:0]               entry_price,
  output logic signed [63:0]        amount,
  output logic signed [63:0]        entry_notional,
  output logic signed [63:0]        exit_notional,
  output logic                      last
);
  import flm_pkg::*;

  localparam int PW = (LOT_DEPTH > 1) ? $clog2(LOT_DEPTH) : 1;
  localparam int CW = $clog2(LOT_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(LOT_DEPTH);
  localparam logic [PW-1:0] LAST_IDX = PW'(LOT_DEPTH - 1);

  logic [31:0] price_mem [LOT_DEPTH];
  logic [22:0] qty_mem [LOT_DEPTH];

  logic [PW-1:0] head_ptr, tail_ptr;
  logic [CW-1:0] lot_count;
  logic signed [1:0] position_dir;
  logic [31:0] episode_open_time;
  logic signed [63:0] entry_sum, exit_sum;

  logic [31:0] t_r, p_r;
  logic        neg_r, was_open, zero_fill;
  logic [22:0] remaining;
  logic [31:0] lp;
  logic [22:0] lq, m;
  logic signed [32:0] diff;
  logic signed [56:0] pnl_p, xn_p;
  logic signed [63:0] pnl, xn;
  logic [54:0] en_mag;
  logic signed [63:0] en_w;
  logic [22:0] mag;
  logic signed [1:0] sgn, pos_dir_r;

  assign sgn = neg_r ? -2'sd1 : 2'sd1;
  assign mag = fill_qty[23] ? ((fill_qty == 24'sh800000) ? QTY_MAX
                                : 23'((~fill_qty) + 24'sd1)) : fill_qty[22:0];

  assign st.qty_zero = zero_fill;
  assign st.has_lots = (lot_count != '0);
  assign st.opposing = (sgn != position_dir);
  assign st.remaining_zero = (remaining == '0);
  assign st.full = (lot_count >= DEPTH_C);
  assign st.was_open = was_open;

  assign en_mag = 55'(remaining) * 55'(p_r);
  assign en_w = neg_r ? -$signed(64'(en_mag)) : $signed(64'(en_mag));

  always_ff @(posedge clk) begin
    if (cmd.head_rd) begin
      lp <= price_mem[head_ptr];
      lq <= qty_mem[head_ptr];
    end
    if (cmd.push) begin
      price_mem[tail_ptr] <= p_r;
      qty_mem[tail_ptr] <= remaining;
    end
    if (cmd.mul_done && lq != m) qty_mem[head_ptr] <= lq - m;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_r <= fill_time;
      p_r <= fill_price;
      neg_r <= fill_qty[23];
    end
    if (cmd.match) begin
      m <= (remaining < lq) ? remaining : lq;
      diff <= $signed({1'b0, p_r}) - $signed({1'b0, lp});
    end
    if (cmd.mul_done) begin
      pnl_p <= $signed({1'b0, m}) * diff;
      xn_p <= $signed({1'b0, m}) * $signed({1'b0, p_r});
    end
  end

  assign pnl = (position_dir < 0) ? -64'(pnl_p) : 64'(pnl_p);
  assign xn = (position_dir < 0) ? -64'(xn_p) : 64'(xn_p);

  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr <= '0;
      tail_ptr <= '0;
      lot_count <= '0;
      position_dir <= '0;
      episode_open_time <= '0;
      entry_sum <= '0;
      exit_sum <= '0;
      remaining <= '0;
      was_open <= 1'b0;
      zero_fill <= 1'b0;
      pos_dir_r <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_exit | cmd.emit_episode | cmd.emit_overflow;
      if (cmd.load) begin
        remaining <= mag;
        zero_fill <= (fill_qty == '0);
        was_open <= (lot_count != '0);
        pos_dir_r <= (lot_count != '0) ? position_dir
                                        : (fill_qty[23] ? -2'sd1 : 2'sd1);
      end
      if (cmd.mul_done) begin
        remaining <= remaining - m;
        if (lq == m) begin
          head_ptr <= (head_ptr == LAST_IDX) ? '0 : head_ptr + 1'b1;
          lot_count <= lot_count - 1'b1;
        end
      end
      if (cmd.emit_exit) begin
        exit_sum <= sat_add(exit_sum, xn);
        kind <= KIND_EXIT;
        event_time <= t_r;
        open_time <= '0;
        direction <= position_dir;
        matched_qty <= m;
        exit_price <= p_r;
        entry_price <= lp;
        amount <= pnl;
        entry_notional <= '0;
        exit_notional <= '0;
        last <= cmd.last;
      end
      if (cmd.emit_episode) begin
        kind <= KIND_EPISODE;
        event_time <= t_r;
        open_time <= episode_open_time;
        direction <= pos_dir_r;
        matched_qty <= '0;
        exit_price <= p_r;
        entry_price <= '0;
        amount <= sat_sub(exit_sum, entry_sum);
        entry_notional <= entry_sum;
        exit_notional <= exit_sum;
        last <= cmd.last;
        entry_sum <= '0;
        exit_sum <= '0;
        position_dir <= '0;
      end
      if (cmd.emit_overflow) begin
        kind <= KIND_OVERFLOW;
        event_time <= t_r;
        open_time <= '0;
        direction <= sgn;
        matched_qty <= remaining;
        exit_price <= '0;
        entry_price <= p_r;
        amount <= '0;
        entry_notional <= '0;
        exit_notional <= '0;
        last <= 1'b1;
      end
      if (cmd.push) begin
        if (lot_count == '0) begin
          episode_open_time <= t_r;
          position_dir <= sgn;
        end
        tail_ptr <= (tail_ptr == LAST_IDX) ? '0 : tail_ptr + 1'b1;
        lot_count <= lot_count + 1'b1;
        entry_sum <= sat_add(entry_sum, en_w);
      end
    end
  end
endmodule
`default_nettype wire

// ----- design/fifo_lot_matcher_pnl_core.sv -----
// FIFO lot matcher with realized P&L.
// Input: pulse start with fill_time, fill_qty, fill_price while busy is low;
// the beat is taken on that edge and busy rises for the fill's duration.
// Output: each result beat shows for one cycle with strobe high; last marks
// the final result of a fill. A zero-quantity fill gives no result.
// Sequence: the accept, then per matched lot a head read, match, multiply
// and emit step; a fill that drains the position adds a check and a closed
// episode record, and one that keeps a remainder adds a check and a tail
// push or overflow record. Each result shows on the cycle after the one
// that emits it.
// The lot FIFO memory has one read port; matches are strictly sequential.
// Reset clears pointers, lot count, position and sums; no clearing pass.
// The receiver cannot stall; results are never held off.
`timescale 1ns / 1ps
`default_nettype none
module fifo_lot_matcher_pnl_core #(
  parameter int LOT_DEPTH = flm_pkg::LotDepthDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [31:0]        fill_time,
  input  wire logic signed [23:0] fill_qty,
  input  wire logic [31:0]        fill_price,
  output logic                    strobe,
  output logic [1:0]              kind,
  output logic [31:0]             event_time,
  output logic [31:0]             open_time,
  output logic signed [1:0]       direction,
  output logic [22:0]             matched_qty,
  output logic [31:0]             exit_price,
  output logic [31:0]             entry_price,
  output logic signed [63:0]      amount,
  output logic signed [63:0]      entry_notional,
  output logic signed [63:0]      exit_notional,
  output logic                    last
);
  import flm_pkg::*;

  flm_cmd_t    cmd;
  flm_status_t st;

  flm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .st(st), .cmd(cmd)
  );

  flm_datapath #(.LOT_DEPTH(LOT_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .fill_time(fill_time), .fill_qty(fill_qty), .fill_price(fill_price),
    .strobe(strobe), .kind(kind), .event_time(event_time),
    .open_time(open_time), .direction(direction), .matched_qty(matched_qty),
    .exit_price(exit_price), .entry_price(entry_price), .amount(amount),
    .entry_notional(entry_notional), .exit_notional(exit_notional),
    .last(last)
  );
endmodule
`default_nettype wire
